/* hdl/lrupr_pkg.sv */
// Package for the LRU page replacement block: sizes, the scan word carried
// along the frame cell chain, and the update word broadcast to the cells.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package lrupr_pkg;

   localparam int FRAMES        = 8;
   localparam int PAGE_BITS     = 16;
   localparam int IDX_W         = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int RANK_W        = IDX_W;
   localparam int COUNT_W       = $clog2(FRAMES + 1);
   localparam int CSR_W         = 4;
   localparam int FRAME_INDEX_W = 3;
   localparam int TOTAL_W       = 32;

   localparam logic [CSR_W-1:0] CSR_RESET = CSR_W'(8);

   // Scan word handed from one frame cell to the next.
   typedef struct packed {
      logic                 valid;
      logic                 found;
      logic [IDX_W-1:0]     hit_idx;
      logic [RANK_W-1:0]    hit_rank;
      logic                 empty_found;
      logic [IDX_W-1:0]     empty_idx;
      logic                 best_set;
      logic [RANK_W-1:0]    best_rank;
      logic [IDX_W-1:0]     best_idx;
      logic [PAGE_BITS-1:0] best_page;
   } carry_type;

   // Update word broadcast to all cells once the scan has finished.
   typedef struct packed {
      logic                 valid;
      logic [IDX_W-1:0]     slot;
      logic                 write_page;
      logic [PAGE_BITS-1:0] page;
      logic                 age_all;
      logic [RANK_W-1:0]    limit;
   } update_type;

endpackage

/* hdl/lrupr_cell.sv */
// One frame cell: holds a frame's page, valid mark and recency rank, folds
// its own state into the scan word and passes it on to the next cell.
// Depends on lrupr_pkg.
`timescale 1ns / 1ps

module lrupr_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [lrupr_pkg::IDX_W-1:0]    cell_index,
   input  logic [lrupr_pkg::COUNT_W-1:0]  active_count,
   input  logic [lrupr_pkg::PAGE_BITS-1:0] ref_page,
   input  lrupr_pkg::carry_type           carry_in,
   input  lrupr_pkg::update_type          update,
   output lrupr_pkg::carry_type           carry_out
);

   logic [lrupr_pkg::PAGE_BITS-1:0] page_ff;
   logic                            valid_ff;
   logic [lrupr_pkg::RANK_W-1:0]    rank_ff;
   lrupr_pkg::carry_type            carry_ff;
   lrupr_pkg::carry_type            carry_in_next;
   logic                            active;

   assign active = (int'(cell_index) < int'(active_count));

   always_comb begin
      carry_in_next = carry_in;
      if (active && valid_ff && (page_ff == ref_page) && !carry_in.found) begin
         carry_in_next.found    = 1'b1;
         carry_in_next.hit_idx  = cell_index;
         carry_in_next.hit_rank = rank_ff;
      end
      if (active && !valid_ff && !carry_in.empty_found) begin
         carry_in_next.empty_found = 1'b1;
         carry_in_next.empty_idx   = cell_index;
      end
      if (active && (!carry_in.best_set || (rank_ff > carry_in.best_rank))) begin
         carry_in_next.best_set  = 1'b1;
         carry_in_next.best_rank = rank_ff;
         carry_in_next.best_idx  = cell_index;
         carry_in_next.best_page = page_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carry_ff <= '0;
      end else begin
         carry_ff <= carry_in_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rank_ff  <= '0;
      end else if (update.valid) begin
         if (update.slot == cell_index) begin
            rank_ff <= '0;
            if (update.write_page) begin
               valid_ff <= 1'b1;
            end
         end else if (valid_ff && (update.age_all || (rank_ff < update.limit))) begin
            rank_ff <= lrupr_pkg::RANK_W'(rank_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (update.valid && (update.slot == cell_index) && update.write_page) begin
         page_ff <= update.page;
      end
   end

   assign carry_out = carry_ff;

endmodule

/* hdl/lru_page_replacement.sv */
// A taken reference word is registered, and its scan word crosses the cell chain through the register
// of every cell; the decision is registered as the word leaves the last cell, and the result is strobed.
// A new reference word is not taken until the last is through: busy holds through the strobe
// cycle, at whose end the rank and page update lands, so a start is taken again once busy drops.
// Reset (synchronous, active high) empties all frames, clears ranks and totals and sets
// frames_in_use to 8. The receiver cannot stall: each result is strobed for one cycle.
`timescale 1ns / 1ps

module lru_page_replacement (
   input  logic                              clock,
   input  logic                              reset,
   // Reference channel.
   input  logic                              start,
   output logic                              busy,
   input  logic [lrupr_pkg::PAGE_BITS-1:0]   req_page,
   // Result channel.
   output logic                              rsp_strobe,
   output logic                              rsp_hit,
   output logic [lrupr_pkg::FRAME_INDEX_W-1:0] rsp_frame_index,
   output logic                              rsp_evicted_valid,
   output logic [lrupr_pkg::PAGE_BITS-1:0]   rsp_evicted_page,
   output logic [lrupr_pkg::TOTAL_W-1:0]     rsp_hit_total,
   output logic [lrupr_pkg::TOTAL_W-1:0]     rsp_fault_total,
   // Configuration channel: frames_in_use.
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lrupr_pkg::CSR_W-1:0]       csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [lrupr_pkg::CSR_W-1:0]     frames_ff;
   logic [lrupr_pkg::COUNT_W-1:0]   active_count;
   logic [lrupr_pkg::PAGE_BITS-1:0] page_ff;
   logic                            launch_ff;
   logic [lrupr_pkg::TOTAL_W-1:0]   hits_ff, hits_in;
   logic [lrupr_pkg::TOTAL_W-1:0]   faults_ff, faults_in;

   lrupr_pkg::carry_type  carry [0:lrupr_pkg::FRAMES];
   lrupr_pkg::carry_type  result;
   lrupr_pkg::update_type update_ff, update_in;

   logic                            rsp_strobe_ff;
   logic                            rsp_hit_ff, rsp_hit_in;
   logic [lrupr_pkg::IDX_W-1:0]     rsp_slot_ff;
   logic                            rsp_ev_valid_ff, rsp_ev_valid_in;
   logic [lrupr_pkg::PAGE_BITS-1:0] rsp_ev_page_ff, rsp_ev_page_in;

   logic accept;
   logic scan_done;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   // The frame count register is clamped to one at the bottom and to the
   // number of cells at the top before the cells see it.
   always_comb begin
      if (frames_ff == '0) begin
         active_count = lrupr_pkg::COUNT_W'(1);
      end else if (int'(frames_ff) > lrupr_pkg::FRAMES) begin
         active_count = lrupr_pkg::COUNT_W'(lrupr_pkg::FRAMES);
      end else begin
         active_count = lrupr_pkg::COUNT_W'(frames_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff <= lrupr_pkg::CSR_RESET;
      end else if (csr_valid && csr_ready) begin
         frames_ff <= csr_data;
      end
   end

   // The scan word enters the first cell empty, marked valid only in the
   // cycle after a reference is taken.
   always_comb begin
      carry[0]       = '0;
      carry[0].valid = launch_ff;
   end

   for (genvar g = 0; g < lrupr_pkg::FRAMES; g++) begin : g_cell
      lrupr_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .cell_index   (lrupr_pkg::IDX_W'(g)),
         .active_count (active_count),
         .ref_page     (page_ff),
         .carry_in     (carry[g]),
         .update       (update_ff),
         .carry_out    (carry[g+1])
      );
   end

   assign result    = carry[lrupr_pkg::FRAMES];
   assign scan_done = (state_ff == ST_SCAN) && result.valid;

   // Decision from the scan word that left the last cell. A hit refreshes the
   // matching frame; a miss fills the lowest empty frame, aging every valid
   // frame, or else replaces the frame with the highest rank.
   always_comb begin
      update_in       = '0;
      update_in.valid = scan_done;
      update_in.page  = page_ff;
      rsp_hit_in      = 1'b0;
      rsp_ev_valid_in = 1'b0;
      rsp_ev_page_in  = '0;
      if (result.found) begin
         rsp_hit_in      = 1'b1;
         update_in.slot  = result.hit_idx;
         update_in.limit = result.hit_rank;
      end else if (result.empty_found) begin
         update_in.slot       = result.empty_idx;
         update_in.write_page = 1'b1;
         update_in.age_all    = 1'b1;
      end else begin
         update_in.slot       = result.best_idx;
         update_in.limit      = result.best_rank;
         update_in.write_page = 1'b1;
         rsp_ev_valid_in      = 1'b1;
         rsp_ev_page_in       = result.best_page;
      end
   end

   // Totals saturate at their all-ones value.
   always_comb begin
      hits_in   = hits_ff;
      faults_in = faults_ff;
      if (scan_done) begin
         if (result.found) begin
            if (hits_ff != '1) begin
               hits_in = hits_ff + 1'b1;
            end
         end else if (faults_ff != '1) begin
            faults_in = faults_ff + 1'b1;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         launch_ff     <= 1'b0;
         update_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
         hits_ff       <= '0;
         faults_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         launch_ff     <= accept;
         update_ff     <= update_in;
         rsp_strobe_ff <= scan_done;
         hits_ff       <= hits_in;
         faults_ff     <= faults_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         page_ff <= req_page;
      end
      if (scan_done) begin
         rsp_hit_ff      <= rsp_hit_in;
         rsp_slot_ff     <= update_in.slot;
         rsp_ev_valid_ff <= rsp_ev_valid_in;
         rsp_ev_page_ff  <= rsp_ev_page_in;
      end
   end

   // The totals change at the same edge that raises the strobe, so the
   // counters themselves serve as the result ports.
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_frame_index   = lrupr_pkg::FRAME_INDEX_W'(rsp_slot_ff);
   assign rsp_evicted_valid = rsp_ev_valid_ff;
   assign rsp_evicted_page  = rsp_ev_page_ff;
   assign rsp_hit_total     = hits_ff;
   assign rsp_fault_total   = faults_ff;

endmodule

/* hdl/lrupr_checker.sv */
// Port-level checker for lru_page_replacement, attached to it by the bind
// statement at the end of this file. Depends on lrupr_pkg.
`timescale 1ns / 1ps

module lrupr_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic                              rsp_strobe,
   input logic                              rsp_hit,
   input logic                              rsp_evicted_valid,
   input logic [lrupr_pkg::PAGE_BITS-1:0]   rsp_evicted_page
);

   // A taken reference keeps the block busy until its result is out.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after a reference word was taken");

   // A result is delivered while the block is still busy and it frees up next.
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy ##1 !busy)
      else $error("result word not followed by return to idle");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   // A hit never replaces a frame.
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_hit) |-> !rsp_evicted_valid)
      else $error("eviction reported on a hit");

   a_evict_page_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_evicted_valid) |-> (rsp_evicted_page == '0))
      else $error("evicted page not zero without an eviction");

endmodule

bind lru_page_replacement lrupr_checker u_lrupr_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_strobe        (rsp_strobe),
   .rsp_hit           (rsp_hit),
   .rsp_evicted_valid (rsp_evicted_valid),
   .rsp_evicted_page  (rsp_evicted_page)
);
